FILE: rtl/frw_pkg.sv
// frw_pkg: shared types and constants for the frame-rate window statistics block
// no dependencies; imported by every module of the block

package frw_pkg;

  localparam int RATE_W     = 28;
  localparam int TS_W       = 32;
  localparam int WLEN_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  // 1e6 us per second times 256 for q8
  localparam logic [RATE_W-1:0] RATE_NUMERATOR = 28'd256000000;

  localparam logic [CFG_IDX_W-1:0] CFG_MON_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR = 2'd2;

  localparam logic              MON_EN_RST  = 1'b1;
  localparam logic [WLEN_W-1:0] WIN_LEN_RST = 7'd60;
  localparam logic [RATE_W-1:0] LOW_THR_RST = 28'd7680;

  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_STORE,
    ST_WALK,
    ST_WALK_END,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_DONE
  } frw_state_t;

  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic div_rate;  // start rate division
    logic div_mean;  // start mean division
    logic cap_rate;  // capture rate quotient
    logic cap_mean;  // capture mean quotient
    logic store;     // write rate into ring, advance pointers
    logic walk_rd;   // issue one ring read
    logic load_out;  // load result register
  } frw_cmd_t;

  typedef struct packed {
    logic enabled;
    logic delta_zero;
    logic div_done;
    logic walk_last;
  } frw_status_t;

endpackage

FILE: rtl/frw_if.sv
// frw_in_if / frw_out_if: valid-ready channels for update items and results
// depends on frw_pkg for field widths

interface frw_in_if
  import frw_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [TS_W-1:0] timestamp_us;

  modport source (output valid, output mode, output timestamp_us, input ready);
  modport sink   (input valid, input mode, input timestamp_us, output ready);
endinterface

interface frw_out_if
  import frw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] current_rate_q8;
  logic [TS_W-1:0]   frame_time_us;
  logic [RATE_W-1:0] min_rate_q8;
  logic [RATE_W-1:0] max_rate_q8;
  logic [RATE_W-1:0] mean_rate_q8;
  logic              low_rate;

  modport source (output valid, output current_rate_q8, output frame_time_us,
                  output min_rate_q8, output max_rate_q8, output mean_rate_q8,
                  output low_rate, input ready);
  modport sink   (input valid, input current_rate_q8, input frame_time_us,
                  input min_rate_q8, input max_rate_q8, input mean_rate_q8,
                  input low_rate, output ready);
endinterface

FILE: rtl/frw_div.sv
// frw_div: restoring divider, one quotient bit per cycle, 32-bit divisor
// depends on frw_pkg for the timestamp width

module frw_div
  import frw_pkg::*;
#(
  parameter int NUM_W = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [TS_W-1:0]  den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [TS_W-1:0]  rem_r, rem_nxt;
  logic [TS_W-1:0]  den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [TS_W:0]    rem_sh, diff;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    diff    = rem_sh - {1'b0, den_r};
    ge      = ~diff[TS_W];
    rem_nxt = ge ? diff[TS_W-1:0] : rem_sh[TS_W-1:0];
    num_nxt = {num_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NUM_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = num_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider did not start");

endmodule

FILE: rtl/frw_ctrl.sv
// frw_ctrl: sequencer for the frame-rate statistics datapath and output handshake
// depends on frw_pkg for the state, command and status types

module frw_ctrl
  import frw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_mode,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  frw_status_t status,
  output frw_cmd_t    cmd
);

  frw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_mode == MODE_UPDATE && status.enabled && !status.delta_zero) begin
          state_nxt = ST_RATE_GO;
        end
      end
      ST_RATE_GO:   state_nxt = ST_RATE_WAIT;
      ST_RATE_WAIT: if (status.div_done) state_nxt = ST_STORE;
      ST_STORE:     state_nxt = ST_WALK;
      ST_WALK:      if (status.walk_last) state_nxt = ST_WALK_END;
      ST_WALK_END:  state_nxt = ST_MEAN_GO;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (status.div_done) state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.div_rate = (state_r == ST_RATE_GO);
    cmd.cap_rate = (state_r == ST_RATE_WAIT) && status.div_done;
    cmd.store    = (state_r == ST_STORE);
    cmd.walk_rd  = (state_r == ST_WALK);
    cmd.div_mean = (state_r == ST_MEAN_GO);
    cmd.cap_mean = (state_r == ST_MEAN_WAIT) && status.div_done;
    cmd.load_out = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before taken");

endmodule

FILE: rtl/frw_dp.sv
// frw_dp: config registers, interval, rate ring memory, window walk and divider
// depends on frw_pkg and frw_div

module frw_dp
  import frw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_mode,
  input  logic [TS_W-1:0]       in_timestamp_us,
  input  frw_cmd_t              cmd,
  output frw_status_t           status,
  output logic [RATE_W-1:0]     current_rate_q8,
  output logic [TS_W-1:0]       frame_time_us,
  output logic [RATE_W-1:0]     min_rate_q8,
  output logic [RATE_W-1:0]     max_rate_q8,
  output logic [RATE_W-1:0]     mean_rate_q8,
  output logic                  low_rate
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = RATE_W + CNT_W;
  localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

  logic              mon_en_r;
  logic [WLEN_W-1:0] win_len_r;
  logic [RATE_W-1:0] low_thr_r;

  logic [TS_W-1:0]   last_ts_r;
  logic [TS_W-1:0]   delta_r;
  logic [AW-1:0]     wpos_r, newest_r, k_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, eff_len;
  logic [LEN_W-1:0]  wl_ext;
  logic [RATE_W-1:0] rate_r, mean_r, min_r, max_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RATE_W-1:0] ring [WINDOW_DEPTH];
  logic [RATE_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic [AW:0]       back_addr;
  logic              acc_en_r;

  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_num, div_quot;
  logic [TS_W-1:0]   div_den;

  logic [RATE_W-1:0] out_rate_r, out_min_r, out_max_r, out_mean_r;
  logic [TS_W-1:0]   out_ft_r;
  logic              out_low_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r  <= MON_EN_RST;
      win_len_r <= WIN_LEN_RST;
      low_thr_r <= LOW_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MON_EN:  mon_en_r  <= cfg_wdata[0];
        CFG_WIN_LEN: win_len_r <= cfg_wdata[WLEN_W-1:0];
        CFG_LOW_THR: low_thr_r <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // window length clamped to 1..depth
  always_comb begin
    wl_ext = LEN_W'(win_len_r);
    if (wl_ext == '0) begin
      eff_len = CNT_W'(1);
    end else if (wl_ext > LEN_W'(WINDOW_DEPTH)) begin
      eff_len = CNT_W'(WINDOW_DEPTH);
    end else begin
      eff_len = CNT_W'(wl_ext);
    end
    cnt_nxt = (cnt_r < eff_len) ? cnt_r + 1'b1 : eff_len;
  end

  // interval, ring pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ts_r <= '0;
      wpos_r    <= '0;
      cnt_r     <= '0;
    end else if (cmd.accept) begin
      if (in_mode == MODE_RESTART) begin
        last_ts_r <= in_timestamp_us;
        wpos_r    <= '0;
        cnt_r     <= '0;
      end else if (mon_en_r) begin
        last_ts_r <= in_timestamp_us;
      end
    end else if (cmd.store) begin
      wpos_r <= (wpos_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      delta_r <= in_timestamp_us - last_ts_r;
    end
    if (cmd.cap_rate) begin
      rate_r <= div_quot[RATE_W-1:0];
    end
    if (cmd.cap_mean) begin
      mean_r <= div_quot[RATE_W-1:0];
    end
    if (cmd.store) begin
      newest_r <= wpos_r;
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[wpos_r] <= rate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      rd_data_r <= ring[rd_addr];
    end
  end

  // walk back from the newest entry, wrapping at the depth
  always_comb begin
    if (k_r > newest_r) begin
      back_addr = {1'b0, newest_r} + (AW + 1)'(WINDOW_DEPTH) - {1'b0, k_r};
    end else begin
      back_addr = {1'b0, newest_r} - {1'b0, k_r};
    end
    rd_addr = back_addr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
      k_r      <= '0;
    end else begin
      acc_en_r <= cmd.walk_rd;
      if (cmd.store) begin
        k_r <= '0;
      end else if (cmd.walk_rd) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      min_r <= rate_r;
      max_r <= rate_r;
      sum_r <= '0;
    end else if (acc_en_r) begin
      sum_r <= sum_r + {{CNT_W{1'b0}}, rd_data_r};
      if (rd_data_r < min_r) min_r <= rd_data_r;
      if (rd_data_r > max_r) max_r <= rd_data_r;
    end
  end

  // shared divider: rate first, then mean
  assign div_start = cmd.div_rate || cmd.div_mean;
  assign div_num   = cmd.div_mean ? sum_r : SUM_W'(RATE_NUMERATOR);
  assign div_den   = cmd.div_mean ? {{(TS_W-CNT_W){1'b0}}, cnt_r} : delta_r;

  frw_div #(
    .NUM_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rate_r <= rate_r;
      out_ft_r   <= delta_r;
      out_min_r  <= min_r;
      out_max_r  <= max_r;
      out_mean_r <= mean_r;
      out_low_r  <= (rate_r < low_thr_r);
    end
  end

  assign current_rate_q8 = out_rate_r;
  assign frame_time_us   = out_ft_r;
  assign min_rate_q8     = out_min_r;
  assign max_rate_q8     = out_max_r;
  assign mean_rate_q8    = out_mean_r;
  assign low_rate        = out_low_r;

  always_comb begin
    status            = '0;
    status.enabled    = mon_en_r;
    status.delta_zero = (in_timestamp_us == last_ts_r);
    status.div_done   = div_done;
    status.walk_last  = ((CNT_W'(k_r) + 1'b1) == cnt_r);
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> (cnt_r != '0) && (cnt_r <= CNT_W'(WINDOW_DEPTH)))
    else $error("sample count out of range after store");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |=> (min_r <= max_r))
    else $error("window minimum above maximum");

endmodule

FILE: rtl/frame_rate_window_statistics.sv
// Frame-rate window statistics. A restart item, a disabled update and an update with
// zero interval are taken without leaving the idle state. Every other update runs one
// divider twice (rate, then mean), producing one quotient bit per cycle, with a walk over
// the ring memory through its single read port, one entry per cycle, between the two
// divisions; its result then waits until the previous result has been taken. A finished
// result waits in the output register while the next item is taken. No reset sweep.

module frame_rate_window_statistics
  import frw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  frw_in_if.sink                in_ch,
  frw_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  frw_cmd_t    cmd;
  frw_status_t status;
  logic        in_ready, out_valid;

  frw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  frw_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_ch.mode),
    .in_timestamp_us (in_ch.timestamp_us),
    .cmd             (cmd),
    .status          (status),
    .current_rate_q8 (out_ch.current_rate_q8),
    .frame_time_us   (out_ch.frame_time_us),
    .min_rate_q8     (out_ch.min_rate_q8),
    .max_rate_q8     (out_ch.max_rate_q8),
    .mean_rate_q8    (out_ch.mean_rate_q8),
    .low_rate        (out_ch.low_rate)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

FILE: verif/frame_rate_window_statistics_test.sv
// frame_rate_window_statistics_test: self-checking bench for the frame-rate window meter
// uses frw_pkg and the frw_in_if / frw_out_if channels; predicts each result in-bench
// directed corner tests first, then randomized traffic over many register settings

module frame_rate_window_statistics_test;
  import frw_pkg::*;

  localparam int RING_DEPTH   = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [RATE_W-1:0] current_rate_q8;
    logic [TS_W-1:0]   frame_time_us;
    logic [RATE_W-1:0] min_rate_q8;
    logic [RATE_W-1:0] max_rate_q8;
    logic [RATE_W-1:0] mean_rate_q8;
    logic              low_rate;
  } frame_stats_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frw_in_if  in_ch ();
  frw_out_if out_ch ();

  frame_rate_window_statistics #(
    .WINDOW_DEPTH(RING_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of registers and state
  logic              mon_en;
  logic [WLEN_W-1:0] win_len;
  logic [RATE_W-1:0] low_thr;
  logic [TS_W-1:0]   prev_ts;
  logic [RATE_W-1:0] rate_ring [RING_DEPTH];
  logic [5:0]        ring_wr;
  int                ring_fill;

  frame_stats_t    expected_stats [$];
  int              error_count;
  bit              gaps_on;
  logic [TS_W-1:0] ts_cursor;
  int              counted_items;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void predict_frame_stats(input logic m, input logic [TS_W-1:0] ts);
    logic [TS_W-1:0]   delta;
    logic [TS_W-1:0]   quot;
    logic [5:0]        newest;
    logic [5:0]        slot;
    logic [63:0]       sum;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] mn;
    logic [RATE_W-1:0] mx;
    int                span;
    frame_stats_t      r;
    if (m == MODE_RESTART) begin
      ring_fill = 0;
      ring_wr   = '0;
      prev_ts   = ts;
      return;
    end
    if (!mon_en) return;
    delta   = ts - prev_ts;
    prev_ts = ts;
    if (delta == '0) return;
    quot = {4'd0, RATE_NUMERATOR} / delta;
    rate = quot[RATE_W-1:0];
    newest = ring_wr;
    rate_ring[newest] = rate;
    ring_wr = newest + 6'd1;
    span = (win_len == '0) ? 1 : ((win_len > RING_DEPTH) ? RING_DEPTH : int'(win_len));
    if (ring_fill < span) ring_fill++;
    if (ring_fill > span) ring_fill = span;
    mn  = rate;
    mx  = rate;
    sum = '0;
    // walk back from the newest slot over the live samples
    for (int k = 0; k < ring_fill; k++) begin
      slot = newest - 6'(k);
      sum  = sum + 64'(rate_ring[slot]);
      if (rate_ring[slot] < mn) mn = rate_ring[slot];
      if (rate_ring[slot] > mx) mx = rate_ring[slot];
    end
    sum = sum / 64'(ring_fill);
    r.current_rate_q8 = rate;
    r.frame_time_us   = delta;
    r.min_rate_q8     = mn;
    r.max_rate_q8     = mx;
    r.mean_rate_q8    = sum[RATE_W-1:0];
    r.low_rate        = (rate < low_thr);
    expected_stats.push_back(r);
  endfunction

  function automatic void check_field(input string label, input logic [TS_W-1:0] want,
                                      input logic [TS_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [TS_W-1:0] pick_interval();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    else if (sel < 45) return $urandom_range(8000, 50000);
    else if (sel < 62) return $urandom_range(1, 2000);
    else if (sel < 75) return $urandom_range(50000, 2000000);
    else if (sel < 85) return $urandom_range(255999000, 256001000);
    else return $urandom();
  endfunction

  function automatic logic [WLEN_W-1:0] pick_length();
    unique case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd64;
      4:       return 7'd63;
      5:       return 7'd65;
      6:       return 7'd127;
      7:       return WIN_LEN_RST;
      8:       return WLEN_W'($urandom_range(3, 12));
      default: return WLEN_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_threshold();
    unique case ($urandom_range(0, 6))
      0:       return '0;
      1:       return LOW_THR_RST;
      2:       return {RATE_W{1'b1}};
      3:       return RATE_NUMERATOR;
      4:       return RATE_W'($urandom_range(0, 256000000));
      5:       return RATE_W'($urandom_range(1000, 40000));
      default: return RATE_W'($urandom());
    endcase
  endfunction

  task automatic send_frame_item(input logic m, input logic [TS_W-1:0] ts);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.timestamp_us <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (m == MODE_RESTART || mon_en) counted_items++;
    predict_frame_stats(m, ts);
  endtask

  task automatic send_update_delta(input logic [TS_W-1:0] d);
    ts_cursor = ts_cursor + d;
    send_frame_item(MODE_UPDATE, ts_cursor);
  endtask

  task automatic send_restart(input logic [TS_W-1:0] ts);
    ts_cursor = ts;
    send_frame_item(MODE_RESTART, ts);
  endtask

  // registers only change once the block has gone quiet
  task automatic set_config(input logic en, input logic [WLEN_W-1:0] len,
                            input logic [RATE_W-1:0] thr);
    in_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MON_EN;
    cfg_wdata <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_idx   <= CFG_WIN_LEN;
    cfg_wdata <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_idx   <= CFG_LOW_THR;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we  <= 1'b0;
    mon_en  = en;
    win_len = len;
    low_thr = thr;
  endtask

  task automatic test_rate_extremes();
    send_update_delta(32'd1000);
    send_update_delta(32'd1);
    send_update_delta(32'd0);
    send_update_delta(32'd256000000);
    send_update_delta(32'd256000001);
    send_update_delta(32'hFFFF_FFFF);
    // 30 fps boundary against the reset threshold
    send_update_delta(32'd33333);
    send_update_delta(32'd33334);
  endtask

  task automatic test_restart_and_wrap();
    send_restart(32'hFFFF_FFF0);
    send_update_delta(32'h20);
    send_restart(32'hFFFF_FFFF);
    send_update_delta(32'd1);
  endtask

  task automatic test_monitor_disable();
    set_config(1'b0, WIN_LEN_RST, LOW_THR_RST);
    send_update_delta(32'd20000);
    send_restart(32'h0001_0000);
    send_update_delta(32'd20000);
    set_config(1'b1, WIN_LEN_RST, LOW_THR_RST);
    send_update_delta(32'd16667);
  endtask

  task automatic test_threshold_edges();
    set_config(1'b1, WIN_LEN_RST, '0);
    send_update_delta(32'd1000);
    set_config(1'b1, WIN_LEN_RST, {RATE_W{1'b1}});
    send_update_delta(32'd1);
    set_config(1'b1, WIN_LEN_RST, RATE_NUMERATOR);
    send_update_delta(32'd1);
  endtask

  task automatic test_window_lengths();
    set_config(1'b1, 7'd1, LOW_THR_RST);
    send_restart(32'd0);
    send_update_delta(32'd10000);
    send_update_delta(32'd40000);
    set_config(1'b1, 7'd0, LOW_THR_RST);
    send_update_delta(32'd20000);
    set_config(1'b1, 7'd64, LOW_THR_RST);
    send_update_delta(32'd8000);
    send_update_delta(32'd60000);
    // shrink the window with more samples held than the new length
    set_config(1'b1, 7'd2, LOW_THR_RST);
    send_update_delta(32'd30000);
    set_config(1'b1, 7'd127, LOW_THR_RST);
    send_update_delta(32'd50000);
  endtask

  task automatic test_random_traffic();
    int   burst;
    logic en;
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      en = ($urandom_range(0, 9) != 0);
      set_config(en, pick_length(), pick_threshold());
      gaps_on = ($urandom_range(0, 3) != 0);
      burst = en ? $urandom_range(30, 150) : $urandom_range(4, 12);
      if ($urandom_range(0, 1) == 1) send_restart($urandom());
      repeat (burst) begin
        if ($urandom_range(0, 49) == 0) send_restart($urandom());
        else send_update_delta(pick_interval());
      end
    end
  endtask

  // result side: random back-pressure, compare against oldest prediction
  initial begin
    int           stall;
    frame_stats_t want;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_stats.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual rate %0d frame time %0d",
                 $time, out_ch.current_rate_q8, out_ch.frame_time_us);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        check_field("current_rate_q8", TS_W'(want.current_rate_q8),
                    TS_W'(out_ch.current_rate_q8));
        check_field("frame_time_us", want.frame_time_us, out_ch.frame_time_us);
        check_field("min_rate_q8", TS_W'(want.min_rate_q8), TS_W'(out_ch.min_rate_q8));
        check_field("max_rate_q8", TS_W'(want.max_rate_q8), TS_W'(out_ch.max_rate_q8));
        check_field("mean_rate_q8", TS_W'(want.mean_rate_q8), TS_W'(out_ch.mean_rate_q8));
        check_field("low_rate", TS_W'(want.low_rate), TS_W'(out_ch.low_rate));
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("frame_rate_window_statistics_test: errors");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_MON_EN;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_RESTART;
    in_ch.timestamp_us = '0;
    gaps_on            = 1'b1;
    error_count        = 0;
    counted_items      = 0;
    mon_en             = MON_EN_RST;
    win_len            = WIN_LEN_RST;
    low_thr            = LOW_THR_RST;
    prev_ts            = '0;
    ring_wr            = '0;
    ring_fill          = 0;
    ts_cursor          = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rate_extremes();
    test_restart_and_wrap();
    test_monitor_disable();
    test_threshold_edges();
    test_window_lengths();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("frame_rate_window_statistics_test: clean");
    end else begin
      $display("frame_rate_window_statistics_test: errors");
    end
    $finish;
  end

endmodule

FILE: frame_rate_window_statistics.f
rtl/frw_pkg.sv
rtl/frw_if.sv
rtl/frw_div.sv
rtl/frw_ctrl.sv
rtl/frw_dp.sv
rtl/frame_rate_window_statistics.sv
verif/frame_rate_window_statistics_test.sv
